FILE: rtl/reassembly_key_match_table_macros.svh
// Assertion macros for the reassembly key match table.
// Included by the top level only; no other dependencies.
`ifndef REASSEMBLY_KEY_MATCH_TABLE_MACROS_SVH
`define REASSEMBLY_KEY_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RKMT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RKMT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rkmt_pkg.sv
// Shared types and command codes for the reassembly key match table.
// No dependencies; used by rkmt_cell and the top level.
`timescale 1ns / 1ps

package rkmt_pkg;

  localparam int HANDLE_W = 8;
  localparam int KEY_W    = 12;
  localparam int TYPE_W   = 16;
  localparam int INDEX_W  = 16;
  localparam int SLOT_W   = 6;
  localparam int CMD_W    = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  // Command token handed from cell to cell, collecting the result on its way
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    src;
    logic [KEY_W-1:0]    dst;
    logic [TYPE_W-1:0]   typ;
    logic [INDEX_W-1:0]  idx;
    logic                done;
    logic                hit;
    logic [HANDLE_W-1:0] rhandle;
    logic [SLOT_W-1:0]   rslot;
    logic                any_valid;
  } tok_t;

endpackage

FILE: rtl/rkmt_cell.sv
// One slot of the key match table: holds the slot and works on a passing token.
// Depends on rkmt_pkg.
`timescale 1ns / 1ps

module rkmt_cell #(
  parameter int IDX = 0,
  parameter int HW  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_in_vld,
  input  rkmt_pkg::tok_t tok_in,
  output logic          tok_out_vld,
  output rkmt_pkg::tok_t tok_out
);

  logic                           valid_r, valid_nxt;
  logic [HW-1:0]                  handle_r;
  logic [rkmt_pkg::KEY_W-1:0]     src_r;
  logic [rkmt_pkg::KEY_W-1:0]     dst_r;
  logic [rkmt_pkg::TYPE_W-1:0]    typ_r;
  logic                           wr_en;
  logic                           tok_vld_r;
  rkmt_pkg::tok_t                 tok_r, tok_nxt;
  logic                           key_match;
  logic                           handle_match;

  assign key_match    = (src_r == tok_in.src) && (dst_r == tok_in.dst) &&
                        (typ_r == tok_in.typ);
  assign handle_match = (handle_r == tok_in.handle[HW-1:0]);

  // Apply the command to this slot unless an earlier cell already served it
  always_comb begin
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    tok_nxt   = tok_in;
    if (tok_in_vld) begin
      case (tok_in.cmd)
        rkmt_pkg::CMD_CLEAR: begin
          valid_nxt = 1'b0;
        end
        rkmt_pkg::CMD_ADD: begin
          if (!tok_in.done && !valid_r) begin
            valid_nxt       = 1'b1;
            wr_en           = 1'b1;
            tok_nxt.done    = 1'b1;
            tok_nxt.hit     = 1'b1;
            tok_nxt.rhandle = tok_in.handle;
            tok_nxt.rslot   = rkmt_pkg::SLOT_W'(IDX);
          end
        end
        rkmt_pkg::CMD_FIND: begin
          if (!tok_in.done && valid_r && key_match) begin
            tok_nxt.done    = 1'b1;
            tok_nxt.hit     = 1'b1;
            tok_nxt.rhandle = rkmt_pkg::HANDLE_W'(handle_r);
            tok_nxt.rslot   = rkmt_pkg::SLOT_W'(IDX);
          end
        end
        rkmt_pkg::CMD_RELEASE: begin
          if (!tok_in.done && valid_r && handle_match) begin
            valid_nxt       = 1'b0;
            tok_nxt.done    = 1'b1;
            tok_nxt.hit     = 1'b1;
            tok_nxt.rhandle = tok_in.handle;
            tok_nxt.rslot   = rkmt_pkg::SLOT_W'(IDX);
          end
        end
        rkmt_pkg::CMD_READ: begin
          if (tok_in.idx == rkmt_pkg::INDEX_W'(IDX) && valid_r) begin
            tok_nxt.done    = 1'b1;
            tok_nxt.hit     = 1'b1;
            tok_nxt.rhandle = rkmt_pkg::HANDLE_W'(handle_r);
            tok_nxt.rslot   = rkmt_pkg::SLOT_W'(IDX);
          end
        end
        default: begin
        end
      endcase
      tok_nxt.any_valid = tok_in.any_valid | valid_nxt;
    end
  end

  // Slot valid mark and token hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_vld_r <= tok_in_vld;
    end
  end

  // Slot payload, written on add, and the token register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      handle_r <= tok_in.handle[HW-1:0];
      src_r    <= tok_in.src;
      dst_r    <= tok_in.dst;
      typ_r    <= tok_in.typ;
    end
    tok_r <= tok_nxt;
  end

  assign tok_out_vld = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

FILE: rtl/reassembly_key_match_table.sv
// Top level of the reassembly key match table: a chain of slot cells.
// Depends on rkmt_pkg, rkmt_cell and reassembly_key_match_table_macros.svh.
// Usage:
//   Input channel (in_*): one command per transfer: clear, add, find,
//   release or read slot, with handle, three-part key and slot index.
//   Output channel (out_*): exactly one result per command, in order:
//   hit, handle, slot and whether the table is empty afterwards.
//   A command enters the first cell and moves one cell per cycle along a
//   chain of SLOT_COUNT cells; the lowest slot that serves it marks the
//   token done. The result passes the holding register and then the output
//   register before out_valid rises. One command is in flight at a time, so
//   a new command is taken only once the last result reaches the output.
//   A finished result waits in a holding register while the output register
//   is stalled; in_stall stays high until the result reaches the output.
//   Reset empties the table and drops all pending work.
`timescale 1ns / 1ps

`include "reassembly_key_match_table_macros.svh"

module reassembly_key_match_table #(
  parameter int SLOT_COUNT  = 8,
  parameter int HANDLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_handle,
  input  logic [11:0] in_source_key,
  input  logic [11:0] in_dest_key,
  input  logic [15:0] in_type_key,
  input  logic [15:0] in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [7:0]  out_found_handle,
  output logic [5:0]  out_found_slot,
  output logic        out_table_empty
);

  localparam int HW = (HANDLE_BITS < rkmt_pkg::HANDLE_W) ? HANDLE_BITS : rkmt_pkg::HANDLE_W;
  localparam logic [rkmt_pkg::HANDLE_W-1:0] HMASK = rkmt_pkg::HANDLE_W'((1 << HW) - 1);

  logic           in_xfer;
  logic           busy_r, busy_nxt;
  logic           pend_vld_r, pend_vld_nxt;
  rkmt_pkg::tok_t pend_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_load;
  logic           out_hit_r;
  logic [7:0]     out_handle_r;
  logic [5:0]     out_slot_r;
  logic           out_empty_r;
  rkmt_pkg::tok_t entry_tok;

  rkmt_pkg::tok_t chain_tok [SLOT_COUNT+1];
  logic [SLOT_COUNT:0] chain_vld;

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;

  // Build the entry token from the input fields
  always_comb begin
    entry_tok        = '0;
    entry_tok.cmd    = in_cmd;
    entry_tok.handle = in_handle & HMASK;
    entry_tok.src    = in_source_key;
    entry_tok.dst    = in_dest_key;
    entry_tok.typ    = in_type_key;
    entry_tok.idx    = in_slot_index;
  end
  assign chain_tok[0] = entry_tok;
  assign chain_vld[0] = in_xfer;

  // Row of slot cells
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    rkmt_cell #(
      .IDX (g),
      .HW  (HW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_in_vld  (chain_vld[g]),
      .tok_in      (chain_tok[g]),
      .tok_out_vld (chain_vld[g+1]),
      .tok_out     (chain_tok[g+1])
    );
  end

  // Hold the finished token, then move it to the output register when free
  assign out_load = pend_vld_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt      = busy_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end
    if (chain_vld[SLOT_COUNT]) begin
      pend_vld_nxt = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      pend_vld_nxt  = 1'b0;
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (chain_vld[SLOT_COUNT]) begin
      pend_r <= chain_tok[SLOT_COUNT];
    end
    if (out_load) begin
      out_hit_r    <= pend_r.hit;
      out_handle_r <= pend_r.rhandle;
      out_slot_r   <= pend_r.rslot;
      out_empty_r  <= !pend_r.any_valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_handle = out_handle_r;
  assign out_found_slot   = out_slot_r;
  assign out_table_empty  = out_empty_r;

  // Checks
  `RKMT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_xfer, busy_r, "accept did not mark busy")
  `RKMT_ASSERT_NOW(a_pend_busy, clk, rst_n, pend_vld_r, busy_r, "held result while not busy")
  `RKMT_ASSERT_NOW(a_one_token, clk, rst_n, 1'b1,
    $onehot0({chain_vld[SLOT_COUNT:1], pend_vld_r}), "more than one command in flight")
  `RKMT_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid_r && !out_hit_r,
    (out_handle_r == 8'd0) && (out_slot_r == 6'd0), "miss reports nonzero handle or slot")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for reassembly_key_match_table: directed, random and back-pressure
// traffic against a slot-table predictor kept inside the bench.
// Depends on rkmt_pkg and the reassembly_key_match_table RTL only.
`timescale 1ns / 1ps

module tb_top;
  import rkmt_pkg::*;

  localparam int SLOTS          = 8;
  localparam int HANDLE_BITS    = 8;
  localparam int KEY_POOL       = 4;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;
  localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((1 << HANDLE_BITS) - 1);

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    src;
    logic [KEY_W-1:0]    dst;
    logic [TYPE_W-1:0]   typ;
    logic [INDEX_W-1:0]  idx;
  } table_cmd_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic                empty;
  } table_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [HANDLE_W-1:0] in_handle;
  logic [KEY_W-1:0]    in_source_key;
  logic [KEY_W-1:0]    in_dest_key;
  logic [TYPE_W-1:0]   in_type_key;
  logic [INDEX_W-1:0]  in_slot_index;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [SLOT_W-1:0]   out_found_slot;
  logic                out_table_empty;

  // Predicted table contents
  logic [SLOTS-1:0]    tbl_valid;
  logic [HANDLE_W-1:0] tbl_handle [SLOTS];
  logic [KEY_W-1:0]    tbl_src    [SLOTS];
  logic [KEY_W-1:0]    tbl_dst    [SLOTS];
  logic [TYPE_W-1:0]   tbl_typ    [SLOTS];

  // Recurring keys and handles so that finds hit and duplicates occur
  logic [KEY_W-1:0]    pool_src    [KEY_POOL];
  logic [KEY_W-1:0]    pool_dst    [KEY_POOL];
  logic [TYPE_W-1:0]   pool_typ    [KEY_POOL];
  logic [HANDLE_W-1:0] pool_handle [KEY_POOL];

  table_result_t awaited_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          phase_count = 0;
  stall_mode_t stall_mode = STALL_NONE;

  reassembly_key_match_table #(
    .SLOT_COUNT  (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_handle        (in_handle),
    .in_source_key    (in_source_key),
    .in_dest_key      (in_dest_key),
    .in_type_key      (in_type_key),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_found_handle (out_found_handle),
    .out_found_slot   (out_found_slot),
    .out_table_empty  (out_table_empty)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one command to the predicted table and return its result
  function automatic table_result_t predict_table(input table_cmd_t c);
    table_result_t       r;
    logic [HANDLE_W-1:0] h;
    logic                done;
    r    = '0;
    h    = c.handle & HANDLE_MASK;
    done = 1'b0;
    case (c.cmd)
      CMD_CLEAR: tbl_valid = '0;
      CMD_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_handle[i] = h;
            tbl_src[i]    = c.src;
            tbl_dst[i]    = c.dst;
            tbl_typ[i]    = c.typ;
            r.hit = 1'b1; r.handle = h; r.slot = SLOT_W'(i);
            done = 1'b1;
          end
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tbl_valid[i] && tbl_src[i] == c.src && tbl_dst[i] == c.dst &&
              tbl_typ[i] == c.typ) begin
            r.hit = 1'b1; r.handle = tbl_handle[i]; r.slot = SLOT_W'(i);
            done = 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tbl_valid[i] && tbl_handle[i] == h) begin
            tbl_valid[i] = 1'b0;
            r.hit = 1'b1; r.handle = h; r.slot = SLOT_W'(i);
            done = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (int'(c.idx) < SLOTS) begin
          if (tbl_valid[int'(c.idx)]) begin
            r.hit = 1'b1; r.handle = tbl_handle[int'(c.idx)]; r.slot = SLOT_W'(c.idx);
          end
        end
      end
      default: ;
    endcase
    r.empty = ~(|tbl_valid);
    return r;
  endfunction

  function automatic table_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic [HANDLE_W-1:0] handle,
                                          input logic [KEY_W-1:0] src,
                                          input logic [KEY_W-1:0] dst,
                                          input logic [TYPE_W-1:0] typ,
                                          input logic [INDEX_W-1:0] idx);
    table_cmd_t c;
    c.cmd = cmd; c.handle = handle; c.src = src; c.dst = dst; c.typ = typ; c.idx = idx;
    return c;
  endfunction

  function automatic int pick_valid_slot();
    int used[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) used.push_back(i);
    end
    if (used.size() == 0) return -1;
    return used[$urandom_range(0, used.size() - 1)];
  endfunction

  // Mostly well-formed commands: keys and handles drawn from the live table or the pool
  function automatic table_cmd_t random_table_cmd();
    table_cmd_t c;
    int         roll, s, p, k;
    c = make_cmd(CMD_READ, HANDLE_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
                 TYPE_W'($urandom), INDEX_W'($urandom));
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, KEY_POOL - 1);
    if (roll < 3) begin
      c.cmd = CMD_CLEAR;
    end else if (roll < 6) begin
      c.cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_READ) + 1));
    end else if (roll < 42) begin
      c.cmd = CMD_ADD;
      if ($urandom_range(0, 9) < 3) c.handle = pool_handle[k];
      if ($urandom_range(0, 9) < 4) begin
        c.src = pool_src[k]; c.dst = pool_dst[k]; c.typ = pool_typ[k];
      end
    end else if (roll < 64) begin
      c.cmd = CMD_FIND;
      s = pick_valid_slot();
      p = $urandom_range(0, 9);
      if (s >= 0 && p < 7) begin
        c.src = tbl_src[s]; c.dst = tbl_dst[s]; c.typ = tbl_typ[s];
        // near miss: one key bit off
        if (p == 6) c.typ[$urandom_range(0, TYPE_W - 1)] ^= 1'b1;
      end else if (p < 9) begin
        c.src = pool_src[k]; c.dst = pool_dst[k]; c.typ = pool_typ[k];
      end
    end else if (roll < 84) begin
      c.cmd = CMD_RELEASE;
      s = pick_valid_slot();
      if (s >= 0 && $urandom_range(0, 9) < 7) c.handle = tbl_handle[s];
      else if ($urandom_range(0, 1) == 0) c.handle = pool_handle[k];
    end else begin
      p = $urandom_range(0, 9);
      if (p < 6) c.idx = INDEX_W'($urandom_range(0, SLOTS - 1));
      else if (p < 8) c.idx = INDEX_W'(SLOTS + $urandom_range(0, 7));
    end
    return c;
  endfunction

  // Offer one command and hold it until the transfer completes
  task automatic send_table_cmd(input table_cmd_t c);
    in_valid      <= 1'b1;
    in_cmd        <= c.cmd;
    in_handle     <= c.handle;
    in_source_key <= c.src;
    in_dest_key   <= c.dst;
    in_type_key   <= c.typ;
    in_slot_index <= c.idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    awaited_results.push_back(predict_table(c));
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Pause the sender until every predicted result has been checked
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_directed_commands();
    send_table_cmd(make_cmd(CMD_CLEAR, '0, '0, '0, '0, '0));
    send_table_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, '0));
    // extremes of handle and key
    send_table_cmd(make_cmd(CMD_ADD, '0, '0, '0, '0, '0));
    send_table_cmd(make_cmd(CMD_ADD, '1, '1, '1, '1, '1));
    send_table_cmd(make_cmd(CMD_FIND, '0, '0, '0, '0, '0));
    send_table_cmd(make_cmd(CMD_FIND, '0, '1, '1, '1, '0));
    send_table_cmd(make_cmd(CMD_FIND, '1, '1, '1, TYPE_W'('1) - 1'b1, '1));
    // duplicate handle: release drops only the lowest copy
    send_table_cmd(make_cmd(CMD_ADD, '0, KEY_W'($urandom), KEY_W'($urandom),
                            TYPE_W'($urandom), '0));
    send_table_cmd(make_cmd(CMD_RELEASE, '0, '0, '0, '0, '0));
    send_table_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, INDEX_W'(0)));
    send_table_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, INDEX_W'(2)));
    send_table_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, INDEX_W'(SLOTS)));
    send_table_cmd(make_cmd(CMD_READ, '0, '0, '0, '0, '1));
    // fill the table, then add once more
    for (int i = 0; i < SLOTS - 2; i++) begin
      send_table_cmd(make_cmd(CMD_ADD, HANDLE_W'(8'h10 + i), KEY_W'($urandom),
                              KEY_W'($urandom), TYPE_W'($urandom), '0));
    end
    send_table_cmd(make_cmd(CMD_ADD, HANDLE_W'(8'h40), '0, '0, '0, '0));
    for (int c = int'(CMD_READ) + 1; c < (1 << CMD_W); c++) begin
      send_table_cmd(make_cmd(CMD_W'(c), '1, '1, '1, '1, '1));
    end
    send_table_cmd(make_cmd(CMD_RELEASE, HANDLE_W'(8'h77), '0, '0, '0, '0));
    send_table_cmd(make_cmd(CMD_CLEAR, '1, '1, '1, '1, '1));
    idle_sender(1);
  endtask

  // Bursts of random length with random gaps, long bursts now and then
  task automatic test_random_traffic(input int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_table_cmd(random_table_cmd());
        sent++;
      end
      idle_sender($urandom_range(1, 12));
    end
  endtask

  // Hold the output off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    hold_requests++;
    for (int k = 0; k < 30; k++) send_table_cmd(random_table_cmd());
    idle_sender(1);
  endtask

  task automatic test_pause_and_drain(input int rounds);
    int burst;
    for (int r = 0; r < rounds; r++) begin
      burst = $urandom_range(10, 40);
      for (int k = 0; k < burst; k++) send_table_cmd(random_table_cmd());
      wait_for_drain();
    end
  endtask

  initial begin : run_tests
    tbl_valid = '0;
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_src[k]    = KEY_W'($urandom);
      pool_dst[k]    = KEY_W'($urandom);
      pool_typ[k]    = TYPE_W'($urandom);
      pool_handle[k] = HANDLE_W'($urandom);
    end
    pool_handle[0] = '0;
    pool_handle[1] = '1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_CLEAR;
    in_handle     <= '0;
    in_source_key <= '0;
    in_dest_key   <= '0;
    in_type_key   <= '0;
    in_slot_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    idle_sender(4);

    test_directed_commands();
    test_random_traffic(600);
    test_output_backpressure();
    test_pause_and_drain(6);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: changing stall pattern, with a long hold-off on request
  always @(posedge clk) begin : receiver_pattern
    if (hold_served != hold_requests) begin
      hold_left   = LONG_HOLD;
      hold_served = hold_requests;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      phase_count++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((phase_count % 5) < 2);
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none pending: hit=%0b handle=%0h slot=%0d empty=%0b",
                 $time, out_hit, out_found_handle, out_found_slot, out_table_empty);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, out_hit);
          error_count++;
        end
        if (out_found_handle !== want.handle) begin
          $display("%0t: found_handle mismatch: expected %0h, actual %0h",
                   $time, want.handle, out_found_handle);
          error_count++;
        end
        if (out_found_slot !== want.slot) begin
          $display("%0t: found_slot mismatch: expected %0d, actual %0d",
                   $time, want.slot, out_found_slot);
          error_count++;
        end
        if (out_table_empty !== want.empty) begin
          $display("%0t: table_empty mismatch: expected %0b, actual %0b",
                   $time, want.empty, out_table_empty);
          error_count++;
        end
      end
    end
  end

  // Abort when neither channel has moved a transfer for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rkmt_pkg.sv
rtl/rkmt_cell.sv
rtl/reassembly_key_match_table.sv
dv/tb_top.sv
